FILE: src/assert_macros.svh
// Assertion macros shared by the key matrix note block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge, quiet while reset is held
`define KMM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Plain invariant checked at every clock edge, quiet while reset is held
`define KMM_ASSERT_ALW(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

FILE: src/kmm_pkg.sv
// Shared constants and types for the key matrix to note message block
package kmm_pkg;

  // matrix geometry
  localparam int NUM_ROWS = 11;
  localparam int NUM_COLS = 6;

  // field widths
  localparam int ROW_W    = 4;
  localparam int COL_W    = 6;
  localparam int NOTE_W   = 7;
  localparam int VEL_W    = 7;
  localparam int STATUS_W = 8;
  localparam int SUM_W    = 8;
  localparam int RIDX_W   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int CIDX_W   = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;

  // configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_BASE_NOTE = 1'b0;
  localparam logic REG_PRESS_VEL = 1'b1;

  // message codes and limits
  localparam logic [STATUS_W-1:0] STATUS_NOTE_ON  = 8'h90;
  localparam logic [STATUS_W-1:0] STATUS_NOTE_OFF = 8'h80;
  localparam logic [STATUS_W-1:0] STATUS_NONE     = 8'h00;
  localparam logic [NOTE_W-1:0]   NOTE_LIMIT      = 7'd127;
  localparam logic [NOTE_W-1:0]   BASE_NOTE_RST   = 7'd36;
  localparam logic [VEL_W-1:0]    PRESS_VEL_RST   = 7'd127;

  // what one column lane finds for the current row
  typedef struct packed {
    logic              chg;
    logic              on;
    logic [NOTE_W-1:0] note;
  } lane_res_t;

  typedef lane_res_t [NUM_COLS-1:0] lane_vec_t;

endpackage

FILE: src/kmm_lane.sv
// One column lane: change detect and saturated note number
module kmm_lane (
  input  logic [kmm_pkg::NOTE_W-1:0] base_note_i,
  input  logic [kmm_pkg::ROW_W-1:0]  row_i,
  input  logic                       row_ok_i,
  input  logic [kmm_pkg::CIDX_W-1:0] col_i,
  input  logic                       old_bit_i,
  input  logic                       new_bit_i,
  output kmm_pkg::lane_res_t         res_o
);
  import kmm_pkg::*;

  logic [SUM_W-1:0] row_off;
  logic [SUM_W-1:0] sum;

  // note = base + row * cols + col, clipped at the top of the note range
  assign row_off = SUM_W'(row_i) * SUM_W'(NUM_COLS);
  assign sum     = SUM_W'(base_note_i) + row_off + SUM_W'(col_i);

  always_comb begin
    res_o.chg  = row_ok_i && (old_bit_i != new_bit_i);
    res_o.on   = new_bit_i;
    res_o.note = (sum > SUM_W'(NOTE_LIMIT)) ? NOTE_LIMIT : sum[NOTE_W-1:0];
  end

endmodule

FILE: src/kmm_merge.sv
// Merge stage: holds one row's lane results and issues messages in column order
`include "assert_macros.svh"

module kmm_merge (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load_i,
  input  kmm_pkg::lane_vec_t           lanes_i,
  input  logic                         led_i,
  input  logic [kmm_pkg::VEL_W-1:0]    press_vel_i,
  output logic                         free_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         msg_o,
  output logic [kmm_pkg::STATUS_W-1:0] status_o,
  output logic [kmm_pkg::NOTE_W-1:0]   note_o,
  output logic [kmm_pkg::VEL_W-1:0]    vel_o,
  output logic                         led_o,
  output logic                         last_o
);
  import kmm_pkg::*;

  // item slot
  logic                slot_v_r, slot_v_nxt;
  logic [NUM_COLS-1:0] pend_r, pend_nxt;
  logic [NUM_COLS-1:0] on_r, on_nxt;
  logic [NOTE_W-1:0]   note_r [NUM_COLS];
  logic                led_r;

  // output register
  logic                out_v_r, out_v_nxt;
  logic                msg_r;
  logic [STATUS_W-1:0] status_r;
  logic [NOTE_W-1:0]   note_out_r;
  logic [VEL_W-1:0]    vel_r;
  logic                led_out_r;
  logic                last_r;

  logic [NUM_COLS-1:0] pick;
  logic [NUM_COLS-1:0] rest;
  logic                pick_last;
  logic                pick_msg;
  logic                pick_on;
  logic [NOTE_W-1:0]   pick_note;
  logic                out_load;

  // lowest pending column wins
  assign pick      = pend_r & (~pend_r + NUM_COLS'(1));
  assign rest      = pend_r & ~pick;
  assign pick_last = (rest == '0);
  assign pick_msg  = |pend_r;

  always_comb begin
    pick_on   = 1'b0;
    pick_note = '0;
    for (int c = 0; c < NUM_COLS; c++) begin
      if (pick[c]) begin
        pick_on   = on_r[c];
        pick_note = note_r[c];
      end
    end
  end

  assign out_load = slot_v_r && (!out_v_r || out_ready_i);
  assign free_o   = !slot_v_r || (out_load && pick_last);

  // slot next state
  always_comb begin
    slot_v_nxt = slot_v_r;
    pend_nxt   = pend_r;
    on_nxt     = on_r;
    if (load_i) begin
      slot_v_nxt = 1'b1;
      for (int c = 0; c < NUM_COLS; c++) begin
        pend_nxt[c] = lanes_i[c].chg;
        on_nxt[c]   = lanes_i[c].on;
      end
    end else if (out_load) begin
      pend_nxt   = rest;
      slot_v_nxt = !pick_last;
    end
  end

  always_comb begin
    if (out_load) begin
      out_v_nxt = 1'b1;
    end else if (out_ready_i) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      slot_v_r <= slot_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  // slot payload
  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    on_r   <= on_nxt;
    if (load_i) begin
      led_r <= led_i;
      for (int c = 0; c < NUM_COLS; c++) begin
        note_r[c] <= lanes_i[c].note;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      msg_r      <= pick_msg;
      status_r   <= pick_msg ? (pick_on ? STATUS_NOTE_ON : STATUS_NOTE_OFF) : STATUS_NONE;
      note_out_r <= pick_msg ? pick_note : '0;
      vel_r      <= (pick_msg && pick_on) ? press_vel_i : '0;
      led_out_r  <= led_r;
      last_r     <= pick_last;
    end
  end

  assign out_valid_o = out_v_r;
  assign msg_o       = msg_r;
  assign status_o    = status_r;
  assign note_o      = note_out_r;
  assign vel_o       = vel_r;
  assign led_o       = led_out_r;
  assign last_o      = last_r;

  `KMM_ASSERT_ALW(a_pick_onehot, $onehot0(pick), "more than one column picked")
  `KMM_ASSERT_IMP(a_nomsg_last, out_v_r && !msg_r, last_r, "no-change result not last")
  `KMM_ASSERT_IMP(a_off_vel, out_v_r && status_r == STATUS_NOTE_OFF, vel_r == '0,
                  "note-off with nonzero velocity")
  `KMM_ASSERT_IMP(a_slot_load, load_i, free_o, "item loaded into busy slot")

endmodule

FILE: src/key_matrix_to_midi_notes_unit.sv
// Top level: key state, configuration registers, column lanes and merge stage
//
//  channel | ports                              | transfer when
//  --------+------------------------------------+--------------------------------
//  input   | in_row_index, in_column_bits       | in_valid && in_ready
//  result  | out_message_valid .. out_last      | out_valid && out_ready
//  config  | cfg_psel/penable/pwrite/paddr/...  | psel && penable && pwrite
//
// A row with k changed keys yields max(1, k) results from the merge stage, one per
// cycle while out_ready does not stall the output; each input passes through the
// merge slot and then the output register before its first result is valid. A new
// row is taken while the last result of the previous one moves to the output
// register. Reset clears all key bits and loads the configuration defaults; a
// stalled output holds the slot and, while it holds a row, keeps input ready low.
module key_matrix_to_midi_notes_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [kmm_pkg::ROW_W-1:0]    in_row_index,
  input  logic [kmm_pkg::COL_W-1:0]    in_column_bits,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_message_valid,
  output logic [kmm_pkg::STATUS_W-1:0] out_status_byte,
  output logic [kmm_pkg::NOTE_W-1:0]   out_note_number,
  output logic [kmm_pkg::VEL_W-1:0]    out_velocity,
  output logic                         out_led_on,
  output logic                         out_last,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [kmm_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [kmm_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [kmm_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                         cfg_pready
);
  import kmm_pkg::*;

  logic [NOTE_W-1:0]   base_note_r;
  logic [VEL_W-1:0]    press_vel_r;
  logic [NUM_COLS-1:0] pressed_r [NUM_ROWS];

  logic                accept;
  logic                row_ok;
  logic [RIDX_W-1:0]   ridx;
  logic [NUM_COLS-1:0] cols;
  logic [NUM_COLS-1:0] old_cols;
  logic                led;
  logic                slot_free;
  logic                cfg_wr;
  logic                cfg_idx;
  lane_vec_t           lanes;

  assign accept = in_valid && in_ready;
  assign in_ready = slot_free;
  assign row_ok = ({1'b0, in_row_index} < (ROW_W + 1)'(NUM_ROWS));
  assign ridx   = in_row_index[RIDX_W-1:0];
  assign cols   = NUM_COLS'(in_column_bits);

  // stored row read, out-of-range rows look unchanged
  assign old_cols = row_ok ? pressed_r[ridx] : cols;

  // LED is the OR of all key bits after this row's update
  always_comb begin
    led = 1'b0;
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (row_ok && (ridx == RIDX_W'(r))) begin
        led = led | (|cols);
      end else begin
        led = led | (|pressed_r[r]);
      end
    end
  end

  // key state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        pressed_r[r] <= '0;
      end
    end else if (accept && row_ok) begin
      pressed_r[ridx] <= cols;
    end
  end

  // configuration registers
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_note_r <= BASE_NOTE_RST;
      press_vel_r <= PRESS_VEL_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_BASE_NOTE: base_note_r <= cfg_pwdata[NOTE_W-1:0];
        REG_PRESS_VEL: press_vel_r <= cfg_pwdata[VEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_BASE_NOTE: cfg_prdata = DATA_W'(base_note_r);
      REG_PRESS_VEL: cfg_prdata = DATA_W'(press_vel_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // one lane per column
  for (genvar c = 0; c < NUM_COLS; c++) begin : g_lane
    kmm_lane u_lane (
      .base_note_i (base_note_r),
      .row_i       (in_row_index),
      .row_ok_i    (row_ok),
      .col_i       (CIDX_W'(c)),
      .old_bit_i   (old_cols[c]),
      .new_bit_i   (cols[c]),
      .res_o       (lanes[c])
    );
  end

  kmm_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_i      (accept),
    .lanes_i     (lanes),
    .led_i       (led),
    .press_vel_i (press_vel_r),
    .free_o      (slot_free),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .msg_o       (out_message_valid),
    .status_o    (out_status_byte),
    .note_o      (out_note_number),
    .vel_o       (out_velocity),
    .led_o       (out_led_on),
    .last_o      (out_last)
  );

endmodule
